FILE: hw/rtl/vtc_pkg.sv
// ----------------------------------------------------------------------------
// vtc_pkg
// shared constants, opcodes and arithmetic helpers for the vertex transform
// ----------------------------------------------------------------------------
package vtc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_W     = 67;
  localparam int RND_W     = SUM_W - FRAC_BITS;
  localparam int MV_DEPTH  = 12;
  localparam int PJ_DEPTH  = 16;

  typedef enum logic [1:0] {
    OP_LOAD_MV   = 2'd0,
    OP_LOAD_PJ   = 2'd1,
    OP_VERTEX    = 2'd2,
    OP_RESERVED  = 2'd3
  } opcode_t;

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return 64'(a) * 64'(b);
  endfunction

  // exact dot product plus constant term, rounded half up
  function automatic logic signed [RND_W-1:0] rnd_sum(input logic signed [63:0] p0,
                                                      input logic signed [63:0] p1,
                                                      input logic signed [63:0] p2,
                                                      input logic signed [31:0] c);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2) + (SUM_W'(c) <<< FRAC_BITS)
        + (SUM_W'(1) <<< (FRAC_BITS - 1));
    return s[SUM_W-1:FRAC_BITS];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
    logic ok;
    ok = (&v[RND_W-1:31]) | ~(|v[RND_W-1:31]);
    if (ok) return v[31:0];
    else if (v[RND_W-1]) return 32'sh80000000;
    else return 32'sh7fffffff;
  endfunction

endpackage

FILE: hw/rtl/vertex_transform_clip_classify_core.sv
// ----------------------------------------------------------------------------
// vertex_transform_clip_classify_core
// modelview / projection vertex transform with clip classification
// ----------------------------------------------------------------------------
// Input beats carry an opcode: load a modelview coefficient, load a projection
// coefficient, or transform a vertex. Loads update the stored matrices at the
// accepting edge, except modelview indices above 11, and give no output beat;
// a vertex gives one beat of eye and clip coordinates and z / w / box flags.
// cfg_we with cfg_wdata sets projection_enable; write it only while idle.
// Throughput is one beat per cycle, set by the five-stage multiply / reduce
// pipeline, while out_stall does not hold it: stage 1 does the nine modelview
// products, stage 2 reduces and saturates eye, stage 3 does the twelve
// projection products, stage 4 reduces clip, stage 5 flags.
// Each vertex snapshots the projection matrix on entry, so loads that follow
// never disturb vertices in flight.
// Reset clears both matrices, projection_enable and all valid bits.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_transform_clip_classify_core
  import vtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_eye_x,
  output logic signed [31:0] out_eye_y,
  output logic signed [31:0] out_eye_z,
  output logic signed [31:0] out_clip_x,
  output logic signed [31:0] out_clip_y,
  output logic signed [31:0] out_clip_z,
  output logic signed [31:0] out_clip_w,
  output logic               out_z_negative,
  output logic               out_clip_valid,
  output logic               out_w_positive,
  output logic               out_in_box
);

  logic signed [31:0] mv_r [MV_DEPTH];
  logic signed [31:0] pj_r [PJ_DEPTH];
  logic               pe_r;

  logic advance, accept;
  opcode_t op;

  logic               s1_v_r, s1_pe_r;
  logic signed [63:0] s1_prod_r [9];
  logic signed [63:0] s1_prod_nxt [9];
  logic signed [31:0] s1_tr_r [3];
  logic signed [31:0] s1_pj_r [PJ_DEPTH];

  logic               s2_v_r, s2_pe_r;
  logic signed [31:0] s2_eye_r [3];
  logic signed [31:0] s2_eye_nxt [3];
  logic signed [31:0] s2_pj_r [PJ_DEPTH];

  logic               s3_v_r, s3_pe_r;
  logic signed [31:0] s3_eye_r [3];
  logic signed [63:0] s3_prod_r [12];
  logic signed [63:0] s3_prod_nxt [12];
  logic signed [31:0] s3_tr_r [4];

  logic               s4_v_r, s4_pe_r;
  logic signed [31:0] s4_eye_r [3];
  logic signed [RND_W-1:0] s4_clip_r [4];
  logic signed [RND_W-1:0] s4_clip_nxt [4];

  logic signed [RND_W-1:0] w, nx, ny;
  logic wpos, inbox;

  assign op       = opcode_t'(in_opcode);
  assign advance  = ~(out_valid & out_stall);
  assign in_stall = ~advance;
  assign accept   = in_valid & advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MV_DEPTH; i++) mv_r[i] <= '0;
      for (int i = 0; i < PJ_DEPTH; i++) pj_r[i] <= '0;
      pe_r <= 1'b0;
    end else begin
      if (cfg_we) pe_r <= cfg_wdata;
      if (accept && op == OP_LOAD_MV && in_coeff_index < 4'(MV_DEPTH))
        mv_r[in_coeff_index] <= in_coeff_value;
      if (accept && op == OP_LOAD_PJ) pj_r[in_coeff_index] <= in_coeff_value;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_prod_nxt[i*3+0] = mul32(mv_r[i*4+0], in_pos_x);
      s1_prod_nxt[i*3+1] = mul32(mv_r[i*4+1], in_pos_y);
      s1_prod_nxt[i*3+2] = mul32(mv_r[i*4+2], in_pos_z);
      s2_eye_nxt[i] = sat32(rnd_sum(s1_prod_r[i*3], s1_prod_r[i*3+1],
                                    s1_prod_r[i*3+2], s1_tr_r[i]));
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) s3_prod_nxt[i*3+j] = mul32(s2_pj_r[i*4+j], s2_eye_r[j]);
      s4_clip_nxt[i] = rnd_sum(s3_prod_r[i*3], s3_prod_r[i*3+1],
                               s3_prod_r[i*3+2], s3_tr_r[i]);
    end
  end

  assign w     = s4_clip_r[3];
  assign nx    = -s4_clip_r[0];
  assign ny    = -s4_clip_r[1];
  assign wpos  = w > 0;
  assign inbox = wpos && (s4_clip_r[0] <= w) && (nx <= w) && (s4_clip_r[1] <= w) && (ny <= w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_v_r    <= accept && op == OP_VERTEX;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      out_valid <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pe_r <= pe_r;
      for (int i = 0; i < 9; i++) s1_prod_r[i] <= s1_prod_nxt[i];
      for (int i = 0; i < 3; i++) s1_tr_r[i] <= mv_r[i*4+3];
      for (int i = 0; i < PJ_DEPTH; i++) s1_pj_r[i] <= pj_r[i];

      s2_pe_r <= s1_pe_r;
      for (int i = 0; i < 3; i++) s2_eye_r[i] <= s2_eye_nxt[i];
      for (int i = 0; i < PJ_DEPTH; i++) s2_pj_r[i] <= s1_pj_r[i];

      s3_pe_r <= s2_pe_r;
      for (int i = 0; i < 3; i++) s3_eye_r[i] <= s2_eye_r[i];
      for (int i = 0; i < 12; i++) s3_prod_r[i] <= s3_prod_nxt[i];
      for (int i = 0; i < 4; i++) s3_tr_r[i] <= s2_pj_r[i*4+3];

      s4_pe_r <= s3_pe_r;
      for (int i = 0; i < 3; i++) s4_eye_r[i] <= s3_eye_r[i];
      for (int i = 0; i < 4; i++) s4_clip_r[i] <= s4_clip_nxt[i];

      out_eye_x      <= s4_eye_r[0];
      out_eye_y      <= s4_eye_r[1];
      out_eye_z      <= s4_eye_r[2];
      out_z_negative <= s4_eye_r[2][31];
      out_clip_valid <= s4_pe_r;
      out_clip_x     <= s4_pe_r ? sat32(s4_clip_r[0]) : '0;
      out_clip_y     <= s4_pe_r ? sat32(s4_clip_r[1]) : '0;
      out_clip_z     <= s4_pe_r ? sat32(s4_clip_r[2]) : '0;
      out_clip_w     <= s4_pe_r ? sat32(s4_clip_r[3]) : '0;
      out_w_positive <= s4_pe_r & wpos;
      out_in_box     <= s4_pe_r & inbox;
    end
  end

endmodule

FILE: bench/tb_vertex_transform_clip_classify_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_clip_classify_core
// Drives coefficient loads and vertices into the transform core. For every
// vertex, a local fixed-point model works out the eye and clip coordinates and
// the flags. Each output beat is compared against the oldest expected vertex.
// ----------------------------------------------------------------------------
module tb_vertex_transform_clip_classify_core;
  import vtc_pkg::*;

  typedef struct packed {
    logic signed [31:0] ex, ey, ez, cx, cy, cz, cw;
    logic front, cvalid, wpos, box;
  } vert_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_opcode = OP_LOAD_MV;
  logic [3:0] in_coeff_index = 0;
  logic signed [31:0] in_coeff_value = 0, in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_eye_x, out_eye_y, out_eye_z;
  logic signed [31:0] out_clip_x, out_clip_y, out_clip_z, out_clip_w;
  logic out_z_negative, out_clip_valid, out_w_positive, out_in_box;

  logic signed [31:0] mv_coef [12];
  logic signed [31:0] pj_coef [16];
  logic proj_on;
  vert_res_t pending_verts[$];
  int errors = 0;
  int idle_pct = 22;
  int quiet_cycles = 0;

  vertex_transform_clip_classify_core uut (.*);

  always #10 clk = ~clk;

  // rounded row sum, wide before saturation
  function automatic logic signed [79:0] row_sum(input logic signed [31:0] a0, a1, a2, k,
                                                 input logic signed [31:0] v0, v1, v2);
    logic signed [79:0] s;
    s = 80'(a0) * 80'(v0) + 80'(a1) * 80'(v1) + 80'(a2) * 80'(v2)
        + (80'(k) <<< FRAC_BITS) + (80'sd1 <<< (FRAC_BITS - 1));
    return s >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) return 32'sh7fffffff;
    if (v < -80'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic vert_res_t transform_vertex(input logic signed [31:0] px, py, pz);
    vert_res_t r;
    logic signed [31:0] e [3];
    logic signed [79:0] c [4];
    r = '0;
    for (int i = 0; i < 3; i++)
      e[i] = clamp32(row_sum(mv_coef[4*i], mv_coef[4*i+1], mv_coef[4*i+2],
                             mv_coef[4*i+3], px, py, pz));
    r.ex = e[0]; r.ey = e[1]; r.ez = e[2];
    r.front = e[2] < 0;
    r.cvalid = proj_on;
    if (proj_on) begin
      for (int i = 0; i < 4; i++)
        c[i] = row_sum(pj_coef[4*i], pj_coef[4*i+1], pj_coef[4*i+2], pj_coef[4*i+3],
                       e[0], e[1], e[2]);
      r.wpos = c[3] > 0;
      r.box = r.wpos && c[0] <= c[3] && -c[0] <= c[3] && c[1] <= c[3] && -c[1] <= c[3];
      r.cx = clamp32(c[0]); r.cy = clamp32(c[1]);
      r.cz = clamp32(c[2]); r.cw = clamp32(c[3]);
    end
    return r;
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [3:0] idx,
                           input logic signed [31:0] cv, px, py, pz);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_opcode <= op; in_coeff_index <= idx;
    in_coeff_value <= cv; in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD_MV && idx < MV_DEPTH) mv_coef[idx] = cv;
    else if (op == OP_LOAD_PJ) pj_coef[idx] = cv;
    else if (op == OP_VERTEX) pending_verts = {pending_verts, transform_vertex(px, py, pz)};
  endtask

  task automatic drain_and_set_proj(input logic en);
    in_valid <= 0;
    wait (pending_verts.size() == 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= en;
    @(posedge clk);
    cfg_we <= 0;
    proj_on = en;
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(131072))) - 32'sd65536;
      3: return $signed(32'($urandom_range(1 << 24))) - 32'sd8388608;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_beat(OP_VERTEX, 0, 0, 32'sh7fffffff, 32'sh80000000, 0);
    send_beat(OP_LOAD_MV, 0, 32'sh7fffffff, 0, 0, 0);
    send_beat(OP_LOAD_MV, 5, 32'sh80000000, 0, 0, 0);
    send_beat(OP_LOAD_MV, 10, 32'sh7fffffff, 0, 0, 0);
    send_beat(OP_LOAD_MV, 11, 32'sh80000000, 0, 0, 0);
    send_beat(OP_LOAD_MV, 12, 32'sh12345678, 0, 0, 0);
    send_beat(OP_LOAD_MV, 15, 32'sh7fffffff, 0, 0, 0);
    send_beat(OP_RESERVED, 4'hf, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_beat(OP_VERTEX, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_beat(OP_VERTEX, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_beat(OP_VERTEX, 0, 0, 32'sh00008000, -32'sh00008000, 0);
  endtask

  task automatic test_perspective();
    drain_and_set_proj(1);
    for (int i = 0; i < 12; i++)
      send_beat(OP_LOAD_MV, 4'(i), (i % 5 == 0) ? 32'sh10000 : 0, 0, 0, 0);
    for (int i = 0; i < 16; i++) send_beat(OP_LOAD_PJ, 4'(i), 0, 0, 0, 0);
    send_beat(OP_LOAD_PJ, 0, 32'sh10000, 0, 0, 0);
    send_beat(OP_LOAD_PJ, 5, 32'sh10000, 0, 0, 0);
    send_beat(OP_LOAD_PJ, 14, -32'sh10000, 0, 0, 0);
    send_beat(OP_VERTEX, 0, 0, 32'sh8000, -32'sh8000, -32'sh10000);
    send_beat(OP_VERTEX, 0, 0, 32'sh10000, 32'sh10000, -32'sh10000);
    send_beat(OP_VERTEX, 0, 0, 32'sh20000, 0, -32'sh10000);
    send_beat(OP_VERTEX, 0, 0, 0, 0, 32'sh10000);
    send_beat(OP_VERTEX, 0, 0, 0, 0, 0);
    send_beat(OP_LOAD_PJ, 15, 32'sh7fffffff, 0, 0, 0);
    send_beat(OP_VERTEX, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
  endtask

  task automatic test_random_stream(input int n_items);
    int k;
    logic [1:0] op;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 3) idle_pct = 0;
      if (i == n_items / 2) idle_pct = 22;
      if (i == n_items / 4 || i == 3 * n_items / 4)
        drain_and_set_proj(1'($urandom_range(1)));
      k = $urandom_range(99);
      op = k < 15 ? OP_LOAD_MV : k < 30 ? OP_LOAD_PJ : k < 95 ? OP_VERTEX : OP_RESERVED;
      send_beat(op, 4'($urandom_range(15)), rand_word(), rand_word(), rand_word(),
                rand_word());
    end
  endtask

  // output side: random stall, compare against oldest expected vertex
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_verts.size() == 0) begin
          $error("unexpected output beat");
          errors++;
        end else begin
          vert_res_t x;
          x = pending_verts.pop_front();
          if (out_eye_x !== x.ex) begin $error("eye_x exp %0d got %0d", x.ex, out_eye_x); errors++; end
          if (out_eye_y !== x.ey) begin $error("eye_y exp %0d got %0d", x.ey, out_eye_y); errors++; end
          if (out_eye_z !== x.ez) begin $error("eye_z exp %0d got %0d", x.ez, out_eye_z); errors++; end
          if (out_clip_x !== x.cx) begin $error("clip_x exp %0d got %0d", x.cx, out_clip_x); errors++; end
          if (out_clip_y !== x.cy) begin $error("clip_y exp %0d got %0d", x.cy, out_clip_y); errors++; end
          if (out_clip_z !== x.cz) begin $error("clip_z exp %0d got %0d", x.cz, out_clip_z); errors++; end
          if (out_clip_w !== x.cw) begin $error("clip_w exp %0d got %0d", x.cw, out_clip_w); errors++; end
          if (out_z_negative !== x.front) begin
            $error("z_negative exp %0b got %0b", x.front, out_z_negative); errors++;
          end
          if (out_clip_valid !== x.cvalid) begin $error("clip_valid exp %0b got %0b", x.cvalid, out_clip_valid); errors++; end
          if (out_w_positive !== x.wpos) begin $error("w_positive exp %0b got %0b", x.wpos, out_w_positive); errors++; end
          if (out_in_box !== x.box) begin $error("in_box exp %0b got %0b", x.box, out_in_box); errors++; end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 12; i++) mv_coef[i] = 0;
    for (int i = 0; i < 16; i++) pj_coef[i] = 0;
    proj_on = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed_extremes();
    test_perspective();
    test_random_stream(400);
    drain_and_set_proj(0);
    send_beat(OP_VERTEX, 0, 0, rand_word(), rand_word(), rand_word());
    in_valid <= 0;
    wait (pending_verts.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
